[rtl/core/swr_pkg.sv]
// ----------------------------------------------------------------------------
// swr_pkg
// shared types and constants for the stereo widener with fdn reverb
// ----------------------------------------------------------------------------
package swr_pkg;

    localparam int SmpW = 24;

    typedef struct packed {
        logic signed [SmpW-1:0] left_in;
        logic signed [SmpW-1:0] right_in;
        logic                   end_of_block;
    } t_in_item;

    typedef struct packed {
        logic signed [SmpW-1:0] left_out;
        logic signed [SmpW-1:0] right_out;
        logic                   end_of_block_out;
    } t_out_item;

    typedef enum logic [2:0] {
        REG_LP_B0   = 3'd0,
        REG_A1      = 3'd1,
        REG_A2      = 3'd2,
        REG_SLG     = 3'd3,
        REG_SHG     = 3'd4,
        REG_DAMP    = 3'd5,
        REG_WET     = 3'd6,
        REG_FBG     = 3'd7
    } t_reg_idx;

    // register file seen by the datapath
    typedef struct packed {
        logic signed [23:0] b0;
        logic signed [23:0] a1;
        logic signed [23:0] a2;
        logic [15:0]        slg;
        logic [15:0]        shg;
        logic [16:0]        damp;
        logic [16:0]        wet;
        logic [63:0]        fbg;
    } t_cfg;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_RUN,
        S_OUT
    } t_state;

    // micro steps of the datapath program
    typedef enum logic [5:0] {
        OP_NOP,
        OP_MS,       // mid and side
        OP_BQ_C0,    // biquad taps, shared multiplier
        OP_BQ_C1,
        OP_BQ_C2,
        OP_BQ_A1,
        OP_BQ_A2,
        OP_BQ_END,
        OP_SL_MUL,
        OP_SH_MUL,
        OP_WIDE,
        OP_RD,       // issue line reads
        OP_HAD,
        OP_F_MUL,    // per line, index in line counter
        OP_Z_MUL0,
        OP_Z_MUL1,
        OP_Z_END,
        OP_L_MUL0,
        OP_L_MUL1,
        OP_R_MUL0,
        OP_R_MUL1,
        OP_FIN
    } t_op;

    typedef struct packed {
        logic        clr_en;
        logic [12:0] clr_addr;
        logic        start;
        t_op         op;
        logic [2:0]  bq;
        logic [1:0]  ln;
    } t_cmd;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607)
            sat24 = 24'sh7fffff;
        else if (v < -64'sd8388608)
            sat24 = 24'sh800000;
        else
            sat24 = v[23:0];
    endfunction

    // round half up then arithmetic shift
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                                input logic [4:0] s);
        logic signed [63:0] x;
        x = v + (64'sd1 <<< (s - 5'd1));
        rnd = x >>> s;
    endfunction

endpackage

[rtl/core/stereo_widener_fdn_reverb.sv]
// ----------------------------------------------------------------------------
// stereo_widener_fdn_reverb
// mid/side widener with linkwitz-riley crossover and 4-line fdn reverb
// ----------------------------------------------------------------------------
// flow: one frame at a time; a start cycle, then the step program on one multiplier
// (mid/side, eight biquads of six steps, five band steps, four lines of four, five mix,
// out); a new request is taken only when idle and the output register is free or empties
// reset: synchronous active low; a clearing pass over the addresses of the longest
// line (4800 by default) zeroes the delay lines before the first request is taken
module stereo_widener_fdn_reverb #(
    parameter int LINE0_LEN = 3356,
    parameter int LINE1_LEN = 4043,
    parameter int LINE2_LEN = 4501,
    parameter int LINE3_LEN = 4800
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  swr_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output swr_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import swr_pkg::*;

    localparam int MAXL01 = (LINE0_LEN > LINE1_LEN) ? LINE0_LEN : LINE1_LEN;
    localparam int MAXL23 = (LINE2_LEN > LINE3_LEN) ? LINE2_LEN : LINE3_LEN;
    localparam int MAXL   = (MAXL01 > MAXL23) ? MAXL01 : MAXL23;

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.b0   <= 24'sd1097;
            r_cfg.a1   <= -24'sd8194533;
            r_cfg.a2   <= 24'sd4004612;
            r_cfg.slg  <= 16'd2458;
            r_cfg.shg  <= 16'd12288;
            r_cfg.damp <= 17'd32768;
            r_cfg.wet  <= 17'd16384;
            r_cfg.fbg  <= 64'd4633718132550426991;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_LP_B0: r_cfg.b0   <= pwdata[23:0];
                REG_A1:    r_cfg.a1   <= pwdata[23:0];
                REG_A2:    r_cfg.a2   <= pwdata[23:0];
                REG_SLG:   r_cfg.slg  <= pwdata[15:0];
                REG_SHG:   r_cfg.shg  <= pwdata[15:0];
                REG_DAMP:  r_cfg.damp <= pwdata[16:0];
                REG_WET:   r_cfg.wet  <= pwdata[16:0];
                REG_FBG:   r_cfg.fbg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_LP_B0: prdata = 64'($unsigned(r_cfg.b0));
            REG_A1:    prdata = 64'($unsigned(r_cfg.a1));
            REG_A2:    prdata = 64'($unsigned(r_cfg.a2));
            REG_SLG:   prdata = 64'(r_cfg.slg);
            REG_SHG:   prdata = 64'(r_cfg.shg);
            REG_DAMP:  prdata = 64'(r_cfg.damp);
            REG_WET:   prdata = 64'(r_cfg.wet);
            REG_FBG:   prdata = r_cfg.fbg;
            default: ;
        endcase
    end

    swr_ctrl #(.MAX_LEN(MAXL)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd      (w_cmd)
    );

    swr_dp #(
        .LINE0_LEN(LINE0_LEN),
        .LINE1_LEN(LINE1_LEN),
        .LINE2_LEN(LINE2_LEN),
        .LINE3_LEN(LINE3_LEN)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_cfg  (r_cfg),
        .i_in   (i_in_data),
        .o_out  (o_out_data)
    );
endmodule

[rtl/core/swr_ram.sv]
// ----------------------------------------------------------------------------
// swr_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module swr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/swr_ctrl.sv]
// ----------------------------------------------------------------------------
// swr_ctrl
// sequencer: clearing pass after reset and the per-frame step program
// ----------------------------------------------------------------------------
module swr_ctrl #(
    parameter int MAX_LEN = 4800
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output swr_pkg::t_cmd o_cmd
);
    import swr_pkg::*;

    localparam int AW = $clog2(MAX_LEN);

    t_state       r_state, n_state;
    logic [AW:0]  r_clr, n_clr;
    logic [5:0]   r_pc, n_pc;
    logic [2:0]   r_bq, n_bq;
    logic [1:0]   r_ln, n_ln;
    logic         r_ov, n_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pc    <= '0;
            r_bq    <= '0;
            r_ln    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pc    <= n_pc;
            r_bq    <= n_bq;
            r_ln    <= n_ln;
            r_ov    <= n_ov;
        end
    end

    t_op w_op;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_pc    = r_pc;
        n_bq    = r_bq;
        n_ln    = r_ln;
        n_ov    = r_ov;
        w_op    = OP_NOP;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en   = 1'b1;
                o_cmd.clr_addr = 13'(r_clr[AW-1:0]);
                n_clr = r_clr + 1'b1;
                if (r_clr == (AW+1)'(MAX_LEN - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // the output register is free or empties this cycle
                o_in_ready = !r_ov || i_out_ready;
                if (i_in_valid && o_in_ready) begin
                    o_cmd.start = 1'b1;
                    n_state = S_RUN;
                    n_pc = 6'(OP_MS);
                    n_bq = '0;
                    n_ln = '0;
                end
            end
            S_RUN: begin
                w_op = t_op'(r_pc);
                n_pc = r_pc + 6'd1;
                unique case (w_op)
                    OP_BQ_END: begin
                        n_bq = r_bq + 3'd1;
                        if (r_bq == 3'd7) begin
                            n_pc = 6'(OP_SL_MUL);
                        end else begin
                            n_pc = 6'(OP_BQ_C0);
                        end
                    end
                    OP_Z_END: begin
                        n_ln = r_ln + 2'd1;
                        if (r_ln == 2'd3) begin
                            n_pc = 6'(OP_L_MUL0);
                        end else begin
                            n_pc = 6'(OP_F_MUL);
                        end
                    end
                    OP_FIN: begin
                        n_state = S_OUT;
                    end
                    default: ;
                endcase
            end
            S_OUT: begin
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.op = w_op;
        o_cmd.bq = r_bq;
        o_cmd.ln = r_ln;
    end

    assign o_out_valid = r_ov;
endmodule

[rtl/core/swr_dp.sv]
// ----------------------------------------------------------------------------
// swr_dp
// datapath: one shared multiplier, accumulator, biquad history and delay lines
// ----------------------------------------------------------------------------
module swr_dp #(
    parameter int LINE0_LEN = 3356,
    parameter int LINE1_LEN = 4043,
    parameter int LINE2_LEN = 4501,
    parameter int LINE3_LEN = 4800
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swr_pkg::t_cmd      i_cmd,
    input  swr_pkg::t_cfg      i_cfg,
    input  swr_pkg::t_in_item  i_in,
    output swr_pkg::t_out_item o_out
);
    import swr_pkg::*;

    localparam int LEN [4] = '{LINE0_LEN, LINE1_LEN, LINE2_LEN, LINE3_LEN};

    // frame registers
    logic signed [23:0] r_l, r_r;
    logic               r_eob;
    logic signed [31:0] r_mid, r_side;
    logic signed [31:0] r_y [8];          // biquad outputs
    logic signed [31:0] r_hx1 [8], r_hx2 [8], r_hy1 [8], r_hy2 [8];
    logic signed [63:0] r_acc;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_sl, r_sh, r_wl, r_wr, r_fin;
    logic signed [23:0] r_o [4];
    logic signed [34:0] r_h [4];
    logic signed [31:0] r_z [4];
    logic [12:0]        r_pos [4];
    t_out_item          r_out;

    // coefficients
    logic signed [26:0] w_hb;
    logic signed [27:0] w_c [5];
    logic signed [17:0] w_d, w_m;
    logic signed [17:0] w_dc, w_mc;

    always_comb begin
        w_hb = 27'(2 * 27'(i_cfg.b0)) - 27'(i_cfg.a1);
        w_d  = (i_cfg.damp > 17'd65536) ? 18'sd65536 : 18'($unsigned(i_cfg.damp));
        w_m  = (i_cfg.wet > 17'd65536) ? 18'sd65536 : 18'($unsigned(i_cfg.wet));
        w_dc = 18'sd65536 - w_d;
        w_mc = 18'sd65536 - w_m;
        if (i_cmd.bq[1]) begin
            w_c[0] = 28'(w_hb);
            w_c[1] = -28'sd2 * 28'(w_hb);
            w_c[2] = 28'(w_hb);
        end else begin
            w_c[0] = 28'sd2 * 28'(i_cfg.b0);
            w_c[1] = 28'sd4 * 28'(i_cfg.b0);
            w_c[2] = 28'sd2 * 28'(i_cfg.b0);
        end
        w_c[3] = 28'sd2 * 28'(i_cfg.a1);
        w_c[4] = 28'sd2 * 28'(i_cfg.a2);
    end

    // biquad input: first of a pair takes mid/side, second the previous output
    logic signed [31:0] w_bx;
    always_comb begin
        if (i_cmd.bq[0]) begin
            w_bx = r_y[i_cmd.bq - 3'd1];
        end else begin
            w_bx = i_cmd.bq[2] ? r_side : r_mid;
        end
    end

    // delay line memories
    logic [23:0] w_rd [4];
    logic        w_we [4];
    logic [12:0] w_addr [4];
    logic [23:0] w_wd [4];

    for (genvar g = 0; g < 4; g++) begin : g_line
        localparam int AW = $clog2(LEN[g]);
        swr_ram #(.WIDTH(24), .DEPTH(LEN[g])) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_we[g]),
            .i_addr (w_addr[g][AW-1:0]),
            .i_wdata(w_wd[g]),
            .o_rdata(w_rd[g])
        );
    end

    // shared multiplier operands, registered product
    logic signed [34:0] w_ma;
    logic signed [31:0] w_mb;
    logic signed [31:0] w_ln_h;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        w_ln_h = '0;
        unique case (i_cmd.op)
            OP_BQ_C0: begin w_ma = 35'(w_c[0]); w_mb = w_bx; end
            OP_BQ_C1: begin w_ma = 35'(w_c[1]); w_mb = r_hx1[i_cmd.bq]; end
            OP_BQ_C2: begin w_ma = 35'(w_c[2]); w_mb = r_hx2[i_cmd.bq]; end
            OP_BQ_A1: begin w_ma = 35'(w_c[3]); w_mb = r_hy1[i_cmd.bq]; end
            OP_BQ_A2: begin w_ma = 35'(w_c[4]); w_mb = r_hy2[i_cmd.bq]; end
            OP_SL_MUL: begin w_ma = 35'(r_y[5]); w_mb = 32'(i_cfg.slg); end
            OP_SH_MUL: begin w_ma = 35'(r_y[7]); w_mb = 32'(i_cfg.shg); end
            OP_F_MUL: begin
                w_ma = r_h[i_cmd.ln];
                w_mb = 32'(i_cfg.fbg[16*i_cmd.ln +: 16]);
            end
            OP_Z_MUL0: begin w_ma = 35'(w_dc); w_mb = 32'(rnd(r_prod, 5'd17)); end
            OP_Z_MUL1: begin w_ma = 35'(w_d); w_mb = r_z[i_cmd.ln]; end
            OP_L_MUL0: begin w_ma = 35'(w_mc); w_mb = r_wl; end
            OP_L_MUL1: begin w_ma = 35'(w_m); w_mb = 32'(r_o[0]) + 32'(r_o[2]); end
            OP_R_MUL0: begin w_ma = 35'(w_mc); w_mb = r_wr; end
            OP_R_MUL1: begin w_ma = 35'(w_m); w_mb = 32'(r_o[1]) + 32'(r_o[3]); end
            default: ;
        endcase
    end

    logic signed [63:0] w_sum;
    logic signed [31:0] w_znew;
    // band sums keep one extra bit before the wide saturation
    logic signed [32:0] w_ps, w_pm;
    always_comb begin
        w_sum  = r_acc + r_prod;
        w_znew = sat32(rnd(w_sum, 5'd16));
        w_pm   = 33'(r_y[1]) + 33'(r_y[3]);
        w_ps   = 33'(r_sl) + 33'(r_sh);
    end

    // accumulate sign: feedback terms subtract
    logic r_neg_prev;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_we[j]   = 1'b0;
            w_addr[j] = i_cmd.clr_en ? i_cmd.clr_addr : r_pos[j];
            w_wd[j]   = '0;
            if (i_cmd.clr_en) begin
                w_we[j] = (i_cmd.clr_addr < 13'(LEN[j]));
            end
        end
        if (i_cmd.op == OP_Z_END) begin
            w_we[i_cmd.ln] = 1'b1;
            w_wd[i_cmd.ln] = sat24(64'(r_fin) + 64'(w_znew));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) begin
                r_hx1[k] <= '0;
                r_hx2[k] <= '0;
                r_hy1[k] <= '0;
                r_hy2[k] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                r_z[k]   <= '0;
                r_pos[k] <= '0;
            end
            r_neg_prev <= 1'b0;
        end else begin
            r_prod <= 64'(w_ma) * 64'(w_mb);
            r_neg_prev <= (i_cmd.op == OP_BQ_A1) || (i_cmd.op == OP_BQ_A2);
            unique case (i_cmd.op)
                OP_MS: begin
                    r_mid  <= 32'(rnd(64'(r_l) + 64'(r_r), 5'd1));
                    r_side <= 32'(rnd(64'(r_l) - 64'(r_r), 5'd1));
                end
                OP_BQ_C0: r_acc <= '0;
                OP_BQ_C1, OP_BQ_C2, OP_BQ_A1, OP_BQ_A2: begin
                    r_acc <= r_neg_prev ? r_acc - r_prod : r_acc + r_prod;
                end
                OP_BQ_END: begin
                    r_y[i_cmd.bq]   <= sat32(rnd(r_acc - r_prod, 5'd23));
                    r_hx2[i_cmd.bq] <= r_hx1[i_cmd.bq];
                    r_hx1[i_cmd.bq] <= w_bx;
                    r_hy2[i_cmd.bq] <= r_hy1[i_cmd.bq];
                    r_hy1[i_cmd.bq] <= sat32(rnd(r_acc - r_prod, 5'd23));
                end
                OP_SH_MUL: r_sl <= sat32(rnd(r_prod, 5'd13));
                OP_WIDE: begin
                    r_sh <= sat32(rnd(r_prod, 5'd13));
                end
                OP_RD: begin
                    r_wl  <= sat32(64'(w_pm) + 64'(w_ps));
                    r_wr  <= sat32(64'(w_pm) - 64'(w_ps));
                    r_fin <= 32'(rnd(64'(sat32(64'(w_pm) + 64'(w_ps)))
                                   + 64'(sat32(64'(w_pm) - 64'(w_ps))), 5'd1));
                end
                OP_HAD: begin
                    for (int j = 0; j < 4; j++) begin
                        r_o[j] <= w_rd[j];
                    end
                    r_h[0] <= 35'($signed(w_rd[0])) + 35'($signed(w_rd[1]))
                            + 35'($signed(w_rd[2])) + 35'($signed(w_rd[3]));
                    r_h[1] <= 35'($signed(w_rd[0])) - 35'($signed(w_rd[1]))
                            + 35'($signed(w_rd[2])) - 35'($signed(w_rd[3]));
                    r_h[2] <= 35'($signed(w_rd[0])) + 35'($signed(w_rd[1]))
                            - 35'($signed(w_rd[2])) - 35'($signed(w_rd[3]));
                    r_h[3] <= 35'($signed(w_rd[0])) - 35'($signed(w_rd[1]))
                            - 35'($signed(w_rd[2])) + 35'($signed(w_rd[3]));
                end
                OP_Z_MUL1: r_acc <= r_prod;
                OP_Z_END: begin
                    r_z[i_cmd.ln] <= w_znew;
                    r_pos[i_cmd.ln] <= (r_pos[i_cmd.ln] == 13'(LEN[i_cmd.ln] - 1)) ?
                                       13'd0 : r_pos[i_cmd.ln] + 13'd1;
                end
                OP_L_MUL1: r_acc <= 64'sd2 * r_prod;
                OP_R_MUL0: r_out.left_out <= sat24(rnd(r_acc + r_prod, 5'd17));
                OP_R_MUL1: r_acc <= 64'sd2 * r_prod;
                OP_FIN: begin
                    r_out.right_out        <= sat24(rnd(r_acc + r_prod, 5'd17));
                    r_out.end_of_block_out <= r_eob;
                end
                default: ;
            endcase
            if (i_cmd.start) begin
                r_l   <= i_in.left_in;
                r_r   <= i_in.right_in;
                r_eob <= i_in.end_of_block;
            end
        end
    end

    assign o_out = r_out;
endmodule

[rtl/core/swr_checker.sv]
// ----------------------------------------------------------------------------
// swr_checker
// port-level checks for the stereo widener
// ----------------------------------------------------------------------------
module swr_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input swr_pkg::t_out_item o_out_data,
    input logic               pready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken during frame");

    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result too early");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind stereo_widener_fdn_reverb swr_port_checks u_chk (.*);
